// ----- rtl/dpteq_pkg.sv -----
package dpteq_pkg;

  localparam int DefListDepth = 64;

  localparam logic [1:0] ACT_INSERT   = 2'd0;
  localparam logic [1:0] ACT_DISPATCH = 2'd1;
  localparam logic [1:0] ACT_REMOVE   = 2'd2;
  localparam logic [1:0] ACT_FIND     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NONE_DUE  = 2'd3;

  // One stored event: time, key (kind and tag), period and repeat flag.
  typedef struct packed {
    logic [31:0] etime;
    logic [3:0]  kind;
    logic [15:0] tag;
    logic [23:0] period;
    logic        rep;
  } entry_t;

endpackage

// ----- rtl/dpteq_store.sv -----
module dpteq_store
  import dpteq_pkg::*;
#(
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/dual_priority_timed_event_queue_top.sv -----
// Dual-priority timed event queue with both lists in one memory.
// Insert shifts later-due entries up from the tail; find scans from the head to a key match
// or the end; remove scans, then shifts later entries down; dispatch reads the high
// head, then the low head if needed, drops the due entry and reinserts it if it repeats.
// One request at a time: in_ready stays low until the result word has been taken.
// Reset (rst_n low, synchronous) empties both lists; entry contents are left.
module dual_priority_timed_event_queue_top
  import dpteq_pkg::*;
#(
  parameter int LIST_DEPTH = DefListDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic        in_priority_req,
  input  logic [3:0]  in_event_kind,
  input  logic [15:0] in_event_tag,
  input  logic [31:0] in_due_time,
  input  logic        in_repeats,
  input  logic [23:0] in_period,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_fired_kind,
  output logic [15:0] out_fired_tag,
  output logic [31:0] out_fired_time,
  output logic        out_fired_priority,
  output logic        out_was_requeued,
  output logic        out_all_empty
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] Full = CW'(LIST_DEPTH);

  // The sequencer. Every memory access sets the address in one state and takes the
  // registered read data in the wait state after it.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_HEAD  = 10'b0000000010, // read the high head, then the low head
    S_HWAIT = 10'b0000000100,
    S_LWAIT = 10'b0000001000,
    S_SCAN  = 10'b0000010000, // key search, one entry per S_SCAN/S_SWAIT pass
    S_SWAIT = 10'b0000100000,
    S_DROP  = 10'b0001000000, // shift down after a removed entry
    S_DWAIT = 10'b0010000000,
    S_INS   = 10'b0100000000, // walk down from the tail, shifting up
    S_IWAIT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r [2];
  logic [CW-1:0] cnt_nxt [2];
  logic [CW-1:0] idx_r, idx_nxt;     // walk position within the list
  logic          lst_r, lst_nxt;     // list being worked on
  logic [1:0]    act_r, act_nxt;
  logic [3:0]    kind_r, kind_nxt;
  logic [15:0]   tag_r, tag_nxt;
  logic [31:0]   now_r, now_nxt;
  entry_t        ins_r, ins_nxt;     // entry waiting to be placed
  logic          req_r, req_nxt;     // requeue follows the drop
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [3:0]    ok_r, ok_nxt;
  logic [15:0]   ot_r, ot_nxt;
  logic [31:0]   otm_r, otm_nxt;
  logic          op_r, op_nxt;
  logic          orq_r, orq_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  dpteq_store #(.AW(AW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [AW-1:0] addr_of(logic l, logic [CW-1:0] i);
    return {l, i[IW-1:0]};
  endfunction

  logic [32:0] sum;
  logic [31:0] nt;

  always_comb begin
    sum = {1'b0, rdata.etime} + {9'd0, rdata.period};
    nt  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (nt < now_r) nt = now_r;
  end

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    lst_nxt   = lst_r;
    act_nxt   = act_r;
    kind_nxt  = kind_r;
    tag_nxt   = tag_r;
    now_nxt   = now_r;
    ins_nxt   = ins_r;
    req_nxt   = req_r;
    ov_nxt    = ov_r && !out_ready;
    os_nxt    = os_r;
    ok_nxt    = ok_r;
    ot_nxt    = ot_r;
    otm_nxt   = otm_r;
    op_nxt    = op_r;
    orq_nxt   = orq_r;
    we        = 1'b0;
    waddr     = addr_of(lst_r, idx_r);
    wdata     = ins_r;
    raddr     = addr_of(lst_r, idx_r);

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt  = in_action;
          lst_nxt  = in_priority_req;
          kind_nxt = in_event_kind;
          tag_nxt  = in_event_tag;
          now_nxt  = in_now;
          ins_nxt  = '{etime: in_due_time, kind: in_event_kind, tag: in_event_tag,
                       period: in_period, rep: in_repeats};
          req_nxt  = 1'b0;
          os_nxt   = ST_OK;
          ok_nxt   = '0;
          ot_nxt   = '0;
          otm_nxt  = '0;
          op_nxt   = 1'b0;
          orq_nxt  = 1'b0;
          idx_nxt  = '0;
          case (in_action)
            ACT_INSERT: begin
              if (cnt_r[in_priority_req] == Full) begin
                os_nxt = ST_FULL;
                ov_nxt = 1'b1;
              end else begin
                idx_nxt   = cnt_r[in_priority_req];
                state_nxt = S_INS;
              end
            end
            ACT_DISPATCH: begin
              lst_nxt   = 1'b1;
              state_nxt = S_HEAD;
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end
      S_HEAD: begin
        raddr     = addr_of(lst_r, '0);
        state_nxt = lst_r ? S_HWAIT : S_LWAIT;
      end
      S_HWAIT, S_LWAIT: begin
        if (cnt_r[lst_r] != '0 && now_r >= rdata.etime) begin
          ok_nxt  = rdata.kind;
          ot_nxt  = rdata.tag;
          otm_nxt = rdata.etime;
          op_nxt  = lst_r;
          req_nxt = rdata.rep;
          orq_nxt = rdata.rep;
          ins_nxt = '{etime: nt, kind: rdata.kind, tag: rdata.tag,
                      period: rdata.period, rep: rdata.rep};
          idx_nxt   = '0;
          state_nxt = S_DROP;
        end else if (state_r == S_HWAIT) begin
          lst_nxt   = 1'b0;
          state_nxt = S_HEAD;
        end else begin
          os_nxt    = ST_NONE_DUE;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx_r == cnt_r[lst_r]) begin
          os_nxt    = ST_NOT_FOUND;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (rdata.kind == kind_r && rdata.tag == tag_r) begin
          ok_nxt  = kind_r;
          ot_nxt  = tag_r;
          otm_nxt = rdata.etime;
          op_nxt  = lst_r;
          if (act_r == ACT_REMOVE) begin
            state_nxt = S_DROP;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DROP: begin
        // Read entry idx+1 and move it to idx.
        if (CW'(idx_r + 1'b1) >= cnt_r[lst_r]) begin
          cnt_nxt[lst_r] = cnt_r[lst_r] - 1'b1;
          if (req_r) begin
            idx_nxt   = cnt_r[lst_r] - 1'b1;
            state_nxt = S_INS;
          end else begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          raddr     = addr_of(lst_r, CW'(idx_r + 1'b1));
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        we        = 1'b1;
        wdata     = rdata;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DROP;
      end
      S_INS: begin
        // idx is the open slot; look at the entry just below it.
        if (idx_r == '0) begin
          we             = 1'b1;
          cnt_nxt[lst_r] = cnt_r[lst_r] + 1'b1;
          ov_nxt         = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          raddr     = addr_of(lst_r, CW'(idx_r - 1'b1));
          state_nxt = S_IWAIT;
        end
      end
      S_IWAIT: begin
        if (rdata.etime > ins_r.etime) begin
          we        = 1'b1;
          wdata     = rdata;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = S_INS;
        end else begin
          we             = 1'b1;
          cnt_nxt[lst_r] = cnt_r[lst_r] + 1'b1;
          ov_nxt         = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '{default: '0};
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r  <= idx_nxt;
    lst_r  <= lst_nxt;
    act_r  <= act_nxt;
    kind_r <= kind_nxt;
    tag_r  <= tag_nxt;
    now_r  <= now_nxt;
    ins_r  <= ins_nxt;
    req_r  <= req_nxt;
    os_r   <= os_nxt;
    ok_r   <= ok_nxt;
    ot_r   <= ot_nxt;
    otm_r  <= otm_nxt;
    op_r   <= op_nxt;
    orq_r  <= orq_nxt;
  end

  assign out_valid          = ov_r;
  assign out_status         = os_r;
  assign out_fired_kind     = ok_r;
  assign out_fired_tag      = ot_r;
  assign out_fired_time     = otm_r;
  assign out_fired_priority = op_r;
  assign out_was_requeued   = orq_r;
  assign out_all_empty      = (cnt_r[0] == '0) && (cnt_r[1] == '0);

endmodule

// ----- rtl/dpteq_checker.sv -----
module dpteq_checker
  import dpteq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic        out_was_requeued,
  input logic [31:0] out_fired_time
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_req_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_requeued |-> out_status == ST_OK)
    else $error("requeue reported on a failed request");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_fired_time == 32'd0)
    else $error("event time on a failed request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

bind dual_priority_timed_event_queue_top dpteq_checker u_dpteq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_was_requeued(out_was_requeued), .out_fired_time(out_fired_time)
);
